@@ hdl/rcppm_pkg.sv @@
// Shared types and constants for the RC pulse-position channel decoder.
// Used by rcppm_apb_regs, rcppm_decode_core and rc_ppm_channel_decoder.
package rcppm_pkg;

    // Width of the free-running capture timer.
    localparam int STAMP_BITS = 16;
    // A channel width is half a timestamp difference.
    localparam int WIDTH_BITS = STAMP_BITS - 1;

    // Event kinds.
    localparam logic KIND_EDGE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // Edge counter values with a special meaning.
    localparam logic [2:0] IDX_SYNC       = 3'd0;
    localparam logic [2:0] IDX_LAST_STICK = 3'd5;
    localparam logic [2:0] IDX_AUX_SIX    = 3'd6;
    localparam logic [2:0] IDX_AUX_SEVEN  = 3'd7;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_NEG_POLARITY = 2'd0;
    localparam logic [1:0] REG_THR_ON_CH3   = 2'd1;
    localparam logic [1:0] REG_SWAP_RP      = 2'd2;
    localparam logic [1:0] REG_NEUTRAL      = 2'd3;

    localparam logic [7:0] NEUTRAL_RESET = 8'd128;

    typedef struct packed {
        logic       negative_polarity;
        logic       throttle_on_ch3;
        logic       swap_roll_pitch;
        logic [7:0] stick_neutral;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [15:0] capture_time;
        logic        updates_masked;
    } t_in_item;

    typedef struct packed {
        logic              long_timeout;
        logic              frame_done;
        logic [7:0]        throttle;
        logic signed [7:0] roll;
        logic signed [7:0] pitch;
        logic signed [7:0] yaw;
        logic [7:0]        aux_five;
        logic [7:0]        aux_six;
        logic [7:0]        aux_seven;
        logic              signal_lost;
        logic              fresh_values;
    } t_result;

endpackage

@@ hdl/rcppm_apb_regs.sv @@
// Configuration registers behind an APB-style port.
// Depends on rcppm_pkg for the register indexes and the t_cfg struct.
module rcppm_apb_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output rcppm_pkg::t_cfg    o_cfg
);

    rcppm_pkg::t_cfg r_cfg;
    logic [1:0]      reg_idx;
    logic            wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.negative_polarity <= 1'b0;
            r_cfg.throttle_on_ch3   <= 1'b0;
            r_cfg.swap_roll_pitch   <= 1'b0;
            r_cfg.stick_neutral     <= rcppm_pkg::NEUTRAL_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                rcppm_pkg::REG_NEG_POLARITY: r_cfg.negative_polarity <= pwdata[0];
                rcppm_pkg::REG_THR_ON_CH3:   r_cfg.throttle_on_ch3   <= pwdata[0];
                rcppm_pkg::REG_SWAP_RP:      r_cfg.swap_roll_pitch   <= pwdata[0];
                rcppm_pkg::REG_NEUTRAL:      r_cfg.stick_neutral     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (reg_idx)
            rcppm_pkg::REG_NEG_POLARITY: prdata = {31'd0, r_cfg.negative_polarity};
            rcppm_pkg::REG_THR_ON_CH3:   prdata = {31'd0, r_cfg.throttle_on_ch3};
            rcppm_pkg::REG_SWAP_RP:      prdata = {31'd0, r_cfg.swap_roll_pitch};
            rcppm_pkg::REG_NEUTRAL:      prdata = {24'd0, r_cfg.stick_neutral};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

@@ hdl/rcppm_decode_core.sv @@
// Frame decoder state and result register; one event is processed per enable.
// Depends on rcppm_pkg for the item, result and configuration types.
module rcppm_decode_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  rcppm_pkg::t_in_item   i_item,
    input  rcppm_pkg::t_cfg       i_cfg,
    output rcppm_pkg::t_result    o_result
);

    localparam int SB = rcppm_pkg::STAMP_BITS;
    localparam int WB = rcppm_pkg::WIDTH_BITS;

    logic [2:0]          r_edge_index,  n_edge_index;
    logic                r_edge_select, n_edge_select;
    logic                r_first_to,    n_first_to;
    logic                r_frame_ok,    n_frame_ok;
    logic [SB-1:0]       r_last_stamp,  n_last_stamp;
    logic [WB-1:0]       r_chan_width [4];
    logic [WB-1:0]       n_chan_width [4];
    rcppm_pkg::t_result  r_res,         n_res;

    logic [SB-1:0] stamp;
    logic [SB-1:0] diff;
    logic [WB-1:0] width;
    logic          sel_toggled;
    logic          pol_bad;
    logic          range_ok;
    logic [WB-1:0] thr_w, roll_w, pitch_w;
    logic [1:0]    wr_slot;

    assign stamp       = i_item.capture_time[SB-1:0];
    assign diff        = stamp - r_last_stamp;
    assign width       = diff[SB-1:1];
    assign sel_toggled = ~r_edge_select;
    // Even edge indexes expect the first polarity, odd ones the other.
    assign pol_bad     = (i_cfg.negative_polarity ^ sel_toggled) != ~r_edge_index[0];
    assign wr_slot     = 2'(r_edge_index - 3'd1);
    assign range_ok    = (r_chan_width[0][WB-1:8] == (WB-8)'(1))
                      && (r_chan_width[1][WB-1:8] == (WB-8)'(1))
                      && (r_chan_width[2][WB-1:8] == (WB-8)'(1))
                      && (r_chan_width[3][WB-1:8] == (WB-8)'(1))
                      && (width[WB-1:8] == (WB-8)'(1));

    always_comb begin
        if (i_cfg.throttle_on_ch3) begin
            thr_w = r_chan_width[2];
            if (i_cfg.swap_roll_pitch) begin
                roll_w  = r_chan_width[1];
                pitch_w = r_chan_width[0];
            end else begin
                roll_w  = r_chan_width[0];
                pitch_w = r_chan_width[1];
            end
        end else begin
            thr_w   = r_chan_width[0];
            roll_w  = r_chan_width[1];
            pitch_w = r_chan_width[2];
        end
    end

    always_comb begin
        n_edge_index  = r_edge_index;
        n_edge_select = r_edge_select;
        n_first_to    = r_first_to;
        n_frame_ok    = r_frame_ok;
        n_last_stamp  = r_last_stamp;
        n_chan_width  = r_chan_width;
        n_res         = r_res;
        n_res.frame_done = 1'b0;

        if (i_item.kind == rcppm_pkg::KIND_TIMEOUT) begin
            if (r_first_to) begin
                // Second expiry in a row: restart with the short period.
                n_res.long_timeout = 1'b0;
                n_res.fresh_values = 1'b0;
                n_res.signal_lost  = 1'b1;
                n_frame_ok         = 1'b1;
                n_edge_index       = rcppm_pkg::IDX_SYNC;
                n_edge_select      = i_cfg.negative_polarity;
            end else begin
                n_first_to         = 1'b1;
                n_res.long_timeout = 1'b1;
                n_edge_index       = rcppm_pkg::IDX_SYNC;
            end
        end else begin
            if (i_item.updates_masked) begin
                n_frame_ok = 1'b0;
            end
            n_first_to         = 1'b0;
            n_edge_select      = sel_toggled;
            n_res.long_timeout = 1'b0;
            if (pol_bad) begin
                n_res.fresh_values = 1'b0;
                n_res.signal_lost  = 1'b1;
                n_frame_ok         = 1'b1;
                n_edge_index       = rcppm_pkg::IDX_SYNC;
                n_edge_select      = i_cfg.negative_polarity;
            end else begin
                n_last_stamp = stamp;
                case (r_edge_index)
                    rcppm_pkg::IDX_SYNC: begin
                        n_edge_index = 3'd1;
                    end
                    rcppm_pkg::IDX_LAST_STICK: begin
                        if (!range_ok) begin
                            n_res.fresh_values = 1'b0;
                            n_res.signal_lost  = 1'b1;
                            n_frame_ok         = 1'b1;
                            n_edge_index       = rcppm_pkg::IDX_SYNC;
                            n_edge_select      = i_cfg.negative_polarity;
                        end else begin
                            n_res.throttle     = thr_w[7:0];
                            n_res.roll         = roll_w[7:0] - i_cfg.stick_neutral;
                            n_res.pitch        = pitch_w[7:0] - i_cfg.stick_neutral;
                            n_res.yaw          = r_chan_width[3][7:0] - i_cfg.stick_neutral;
                            n_res.aux_five     = width[7:0];
                            n_res.aux_six      = 8'd0;
                            n_res.aux_seven    = 8'd0;
                            n_res.signal_lost  = 1'b0;
                            n_res.fresh_values = n_frame_ok;
                            n_res.frame_done   = 1'b1;
                            n_frame_ok         = 1'b1;
                            n_edge_index       = rcppm_pkg::IDX_AUX_SIX;
                        end
                    end
                    rcppm_pkg::IDX_AUX_SIX: begin
                        n_res.aux_six = width[7:0];
                        n_edge_index  = rcppm_pkg::IDX_AUX_SEVEN;
                    end
                    rcppm_pkg::IDX_AUX_SEVEN: begin
                        n_res.aux_seven = width[7:0];
                        n_edge_index    = rcppm_pkg::IDX_SYNC;
                    end
                    default: begin
                        // Channels one to four are stored for the frame check.
                        n_chan_width[wr_slot] = width;
                        n_edge_index          = r_edge_index + 3'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_index  <= rcppm_pkg::IDX_SYNC;
            r_edge_select <= 1'b0;
            r_first_to    <= 1'b0;
            r_frame_ok    <= 1'b0;
            r_res         <= '{signal_lost: 1'b1, default: '0};
        end else if (i_en) begin
            r_edge_index  <= n_edge_index;
            r_edge_select <= n_edge_select;
            r_first_to    <= n_first_to;
            r_frame_ok    <= n_frame_ok;
            r_res         <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_last_stamp <= n_last_stamp;
            r_chan_width <= n_chan_width;
        end
    end

    assign o_result = r_res;

endmodule

@@ hdl/rc_ppm_channel_decoder.sv @@
// Top level of the RC pulse-position channel decoder: input register,
// output valid tracking and the configuration port. Uses rcppm_pkg,
// rcppm_apb_regs and rcppm_decode_core.
//
//   channel   direction   handshake                payload
//   in        input       i_in_valid / o_in_stall   t_in_item
//   out       output      o_out_valid / i_out_stall t_result
//   cfg       input       APB write, psel..pready   4 registers at 4*i
//
// One event is taken per cycle while the input is not stalled; it is held in the input
// register, then moves through the decoder into its result register, where it is valid.
// Reset is synchronous; it clears the decoder's edge and frame state, loads the register
// defaults and shows signal_lost high in the held result fields.
// A stalled result holds both stages; the input side stalls only when the
// input register is full and cannot move on.
module rc_ppm_channel_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rcppm_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rcppm_pkg::t_result   o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    rcppm_pkg::t_cfg     cfg;
    rcppm_pkg::t_in_item r_in;
    logic                r_in_valid;
    logic                r_out_valid;
    logic                advance;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    rcppm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rcppm_decode_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (r_in_valid && advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (o_out_data)
    );

endmodule
